FILE: sv/lwc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and a helper function for the line window clipper.
package lwc_pkg;

   localparam int IN_W        = 20;
   localparam int COORD_FRAC  = 4;
   localparam int PARAM_FRAC  = 16;
   localparam int SCREEN_BITS = 12;
   localparam int REG_W       = 13;
   localparam int OUT_W       = 16;
   localparam int NB          = 4;
   localparam int EW          = SCREEN_BITS + COORD_FRAC;
   localparam int CW          = IN_W + 2;
   localparam int DW          = CW - 1;
   localparam int TW          = PARAM_FRAC + 1;
   localparam int PW          = CW + TW + 1;
   localparam int SCREEN_MAX  = 1 << SCREEN_BITS;
   localparam logic [TW-1:0] T_ONE = TW'(1) << PARAM_FRAC;

   localparam logic [REG_W-1:0] WIDTH_RESET  = REG_W'(640);
   localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(480);

   // Byte addresses of the window registers.
   localparam logic [2:0] ADDR_WIDTH  = 3'd0;
   localparam logic [2:0] ADDR_HEIGHT = 3'd4;

   typedef enum logic [1:0] {
      BOUND_NONE  = 2'b00,
      BOUND_ENTER = 2'b01,
      BOUND_LEAVE = 2'b10
   } mode_type;

   typedef struct packed {
      mode_type        mode;
      logic            cut;
      logic            eq;
      logic [DW-1:0]   num;
      logic [DW-1:0]   den;
   } bound_type;

   typedef struct packed {
      logic signed [IN_W-1:0] x0;
      logic signed [IN_W-1:0] y0;
      logic signed [CW-1:0]   dx;
      logic signed [CW-1:0]   dy;
      logic [EW-1:0]          xmax;
      logic [EW-1:0]          ymax;
      logic                   reject;
      bound_type [NB-1:0]     bounds;
   } item_type;

   typedef struct packed {
      item_type                      item;
      logic [NB-1:0][DW-1:0]         rem;
      logic [NB-1:0][PARAM_FRAC-1:0] quo;
   } div_type;

   // Window edge in coordinate format; zero acts as one, large values saturate.
   function automatic logic [EW-1:0] edge_of(logic [REG_W-1:0] r);
      logic [REG_W-1:0]       n;
      logic [SCREEN_BITS-1:0] m;
      n = r;
      if (n == '0) begin
         n = REG_W'(1);
      end
      if (n > REG_W'(SCREEN_MAX)) begin
         n = REG_W'(SCREEN_MAX);
      end
      m = SCREEN_BITS'(n - REG_W'(1));
      return {m, {COORD_FRAC{1'b0}}};
   endfunction

endpackage

FILE: sv/lwc_front.sv
`timescale 1ns / 1ps
// Front end: forms the edge terms of a segment and classifies each window edge.
module lwc_front (
   input  logic signed [lwc_pkg::IN_W-1:0] start_x,
   input  logic signed [lwc_pkg::IN_W-1:0] start_y,
   input  logic signed [lwc_pkg::IN_W-1:0] end_x,
   input  logic signed [lwc_pkg::IN_W-1:0] end_y,
   input  logic [lwc_pkg::EW-1:0]          xmax,
   input  logic [lwc_pkg::EW-1:0]          ymax,
   output lwc_pkg::item_type               item
);

   localparam int CW = lwc_pkg::CW;
   localparam int DW = lwc_pkg::DW;
   localparam int EW = lwc_pkg::EW;

   logic signed [CW-1:0] x0, y0, x1, y1, dx, dy, xm, ym;
   lwc_pkg::bound_type [lwc_pkg::NB-1:0] bnd;

   function automatic lwc_pkg::bound_type classify(logic signed [CW-1:0] p,
                                                   logic signed [CW-1:0] q);
      lwc_pkg::bound_type   b;
      logic signed [CW-1:0] num;
      logic signed [CW-1:0] den;
      b.mode = lwc_pkg::BOUND_NONE;
      b.cut  = 1'b0;
      b.eq   = 1'b0;
      b.num  = '0;
      b.den  = '0;
      if (p == '0) begin
         b.cut = (q < 0);
      end else if (p < 0) begin
         num = -q;
         den = -p;
         if (num <= 0) begin
            b.mode = lwc_pkg::BOUND_NONE;
         end else if (num > den) begin
            b.cut = 1'b1;
         end else begin
            b.mode = lwc_pkg::BOUND_ENTER;
            b.eq   = (num == den);
            b.num  = DW'(num);
            b.den  = DW'(den);
         end
      end else begin
         num = q;
         den = p;
         if (num < 0) begin
            b.cut = 1'b1;
         end else if (num >= den) begin
            b.mode = lwc_pkg::BOUND_NONE;
         end else begin
            b.mode = lwc_pkg::BOUND_LEAVE;
            b.num  = DW'(num);
            b.den  = DW'(den);
         end
      end
      return b;
   endfunction

   assign x0 = CW'(start_x);
   assign y0 = CW'(start_y);
   assign x1 = CW'(end_x);
   assign y1 = CW'(end_y);
   assign dx = x1 - x0;
   assign dy = y1 - y0;
   assign xm = signed'({{(CW-EW){1'b0}}, xmax});
   assign ym = signed'({{(CW-EW){1'b0}}, ymax});

   always_comb begin
      bnd[0] = classify(-dx, x0);
      bnd[1] = classify(dx, xm - x0);
      bnd[2] = classify(-dy, y0);
      bnd[3] = classify(dy, ym - y0);
   end

   always_comb begin
      item.x0     = start_x;
      item.y0     = start_y;
      item.dx     = dx;
      item.dy     = dy;
      item.xmax   = xmax;
      item.ymax   = ymax;
      item.reject = bnd[0].cut | bnd[1].cut | bnd[2].cut | bnd[3].cut;
      item.bounds = bnd;
   end

endmodule

FILE: sv/lwc_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of classified segments between front and back.
module lwc_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lwc_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lwc_pkg::item_type head_item
);

   lwc_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/lwc_back.sv
`timescale 1ns / 1ps
// Back end: pipelined edge ratio division, parameter merge, endpoint multiply and clamp.
module lwc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  lwc_pkg::item_type         q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_accept,
   output logic [lwc_pkg::OUT_W-1:0] rsp_clip_start_x,
   output logic [lwc_pkg::OUT_W-1:0] rsp_clip_start_y,
   output logic [lwc_pkg::OUT_W-1:0] rsp_clip_end_x,
   output logic [lwc_pkg::OUT_W-1:0] rsp_clip_end_y
);

   localparam int PF    = lwc_pkg::PARAM_FRAC;
   localparam int DW    = lwc_pkg::DW;
   localparam int TW    = lwc_pkg::TW;
   localparam int PW    = lwc_pkg::PW;
   localparam int EW    = lwc_pkg::EW;
   localparam int OUT_W = lwc_pkg::OUT_W;
   localparam int NB    = lwc_pkg::NB;

   logic adv;

   lwc_pkg::div_type div_ff [PF];
   lwc_pkg::div_type div_in [PF];
   lwc_pkg::div_type seed;
   logic [PF-1:0]    dvld_ff;

   logic              t_vld_ff, t_rej_ff, t_rej_in;
   logic [TW-1:0]     t0_ff, t0_in, t1_ff, t1_in;
   lwc_pkg::item_type t_item_ff;

   logic                 m_vld_ff, m_rej_ff;
   logic signed [PW-1:0] prod_ff [NB];
   logic signed [PW-1:0] prod_in [NB];
   lwc_pkg::item_type    m_item_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept_ff;
   logic [OUT_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [OUT_W-1:0] sx_in, sy_in, ex_in, ey_in;

   // One restoring division step on every edge of the item.
   function automatic lwc_pkg::div_type div_step(lwc_pkg::div_type s);
      lwc_pkg::div_type r;
      logic [DW:0]      rem2;
      logic             ge;
      r = s;
      for (int b = 0; b < NB; b++) begin
         rem2 = {s.rem[b], 1'b0};
         ge   = (rem2 >= {1'b0, s.item.bounds[b].den});
         r.rem[b] = ge ? DW'(rem2 - {1'b0, s.item.bounds[b].den}) : DW'(rem2);
         r.quo[b] = {s.quo[b][PF-2:0], ge};
      end
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] place(logic signed [lwc_pkg::IN_W-1:0] base,
                                              logic signed [PW-1:0] prod,
                                              logic [EW-1:0] lim);
      logic signed [PW-1:0] v;
      logic signed [PW-1:0] lim_s;
      v     = PW'(base) + (prod >>> PF);
      lim_s = signed'({{(PW-EW){1'b0}}, lim});
      if (v < 0) begin
         v = '0;
      end else if (v > lim_s) begin
         v = lim_s;
      end
      return OUT_W'(v);
   endfunction

   // Hold the whole back pipe while a finished word waits at the output.
   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && q_valid;

   always_comb begin
      seed.item = q_item;
      for (int b = 0; b < NB; b++) begin
         seed.rem[b] = q_item.bounds[b].num;
         seed.quo[b] = '0;
      end
      div_in[0] = div_step(seed);
      for (int k = 1; k < PF; k++) begin
         div_in[k] = div_step(div_ff[k-1]);
      end
   end

   always_comb begin
      logic [TW-1:0] r;
      t0_in = '0;
      t1_in = lwc_pkg::T_ONE;
      for (int b = 0; b < NB; b++) begin
         r = div_ff[PF-1].item.bounds[b].eq ? lwc_pkg::T_ONE
                                            : {1'b0, div_ff[PF-1].quo[b]};
         if (div_ff[PF-1].item.bounds[b].mode == lwc_pkg::BOUND_ENTER && r > t0_in) begin
            t0_in = r;
         end
         if (div_ff[PF-1].item.bounds[b].mode == lwc_pkg::BOUND_LEAVE && r < t1_in) begin
            t1_in = r;
         end
      end
      t_rej_in = div_ff[PF-1].item.reject || (t0_in > t1_in);
   end

   always_comb begin
      prod_in[0] = PW'(t_item_ff.dx) * PW'(signed'({1'b0, t0_ff}));
      prod_in[1] = PW'(t_item_ff.dy) * PW'(signed'({1'b0, t0_ff}));
      prod_in[2] = PW'(t_item_ff.dx) * PW'(signed'({1'b0, t1_ff}));
      prod_in[3] = PW'(t_item_ff.dy) * PW'(signed'({1'b0, t1_ff}));
   end

   always_comb begin
      if (m_rej_ff) begin
         sx_in = '0;
         sy_in = '0;
         ex_in = '0;
         ey_in = '0;
      end else begin
         sx_in = place(m_item_ff.x0, prod_ff[0], m_item_ff.xmax);
         sy_in = place(m_item_ff.y0, prod_ff[1], m_item_ff.ymax);
         ex_in = place(m_item_ff.x0, prod_ff[2], m_item_ff.xmax);
         ey_in = place(m_item_ff.y0, prod_ff[3], m_item_ff.ymax);
      end
      rsp_valid_in = adv ? m_vld_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff      <= '0;
         t_vld_ff     <= 1'b0;
         m_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            dvld_ff  <= {dvld_ff[PF-2:0], q_valid};
            t_vld_ff <= dvld_ff[PF-1];
            m_vld_ff <= t_vld_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < PF; k++) begin
            div_ff[k] <= div_in[k];
         end
         t_rej_ff  <= t_rej_in;
         t0_ff     <= t0_in;
         t1_ff     <= t1_in;
         t_item_ff <= div_ff[PF-1].item;
         m_rej_ff  <= t_rej_ff;
         m_item_ff <= t_item_ff;
         for (int j = 0; j < NB; j++) begin
            prod_ff[j] <= prod_in[j];
         end
         accept_ff <= !m_rej_ff;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         ex_ff     <= ex_in;
         ey_ff     <= ey_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accept       = accept_ff;
   assign rsp_clip_start_x = sx_ff;
   assign rsp_clip_start_y = sy_ff;
   assign rsp_clip_end_x   = ex_ff;
   assign rsp_clip_end_y   = ey_ff;

endmodule

FILE: sv/line_window_clipper_top.sv
`timescale 1ns / 1ps
// Top level of the line window clipper: window registers, front, queue and back.
//
//   channel  direction  handshake                      word
//   req      in         req_valid / req_ready          start_x, start_y, end_x, end_y
//   rsp      out        rsp_valid / rsp_ready          accept, clip_start/end x/y
//   csr      in         psel, penable, pwrite, pready  screen_width @0, screen_height @4
//
// One segment enters per cycle while req_ready is high; each result passes through the queue,
// the 16-stage division pipe and then the merge, multiply and clamp stages.
// Reset is synchronous; it clears the queue and the pipe valid bits and sets the window registers to 640 x 480.
// A stalled rsp holds the whole back pipe; the two-entry queue takes up to two more words,
// then req_ready drops until rsp moves again.
module line_window_clipper_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [lwc_pkg::IN_W-1:0]  req_start_x,
   input  logic signed [lwc_pkg::IN_W-1:0]  req_start_y,
   input  logic signed [lwc_pkg::IN_W-1:0]  req_end_x,
   input  logic signed [lwc_pkg::IN_W-1:0]  req_end_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accept,
   output logic [lwc_pkg::OUT_W-1:0]        rsp_clip_start_x,
   output logic [lwc_pkg::OUT_W-1:0]        rsp_clip_start_y,
   output logic [lwc_pkg::OUT_W-1:0]        rsp_clip_end_x,
   output logic [lwc_pkg::OUT_W-1:0]        rsp_clip_end_y,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [2:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam int REG_W = lwc_pkg::REG_W;

   logic [REG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic             wr_en;
   logic             q_full, q_push, q_pop, q_valid;
   lwc_pkg::item_type front_item, q_item;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en && !paddr[2]) begin
         width_in = pwdata[REG_W-1:0];
      end
      if (wr_en && paddr[2]) begin
         height_in = pwdata[REG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lwc_pkg::WIDTH_RESET;
         height_ff <= lwc_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign prdata = {{(32-REG_W){1'b0}}, paddr[2] ? height_ff : width_ff};

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   lwc_front u_front (
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .xmax    (lwc_pkg::edge_of(width_ff)),
      .ymax    (lwc_pkg::edge_of(height_ff)),
      .item    (front_item)
   );

   lwc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (front_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_item)
   );

   lwc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accept       (rsp_accept),
      .rsp_clip_start_x (rsp_clip_start_x),
      .rsp_clip_start_y (rsp_clip_start_y),
      .rsp_clip_end_x   (rsp_clip_end_x),
      .rsp_clip_end_y   (rsp_clip_end_y)
   );

endmodule
